FILE: sv/u2j_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package u2j_pkg;

    // Event handed from the byte decoder to the string accumulator
    localparam int CP_W        = 31;
    localparam int UNIT_W      = 16;
    localparam int CNT_W       = 32;
    localparam int HASH_W      = 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // result kind codes (also the event kind in the queue)
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // output tdata layout, lowest bit first
    localparam int TDATA_W     = 120;
    localparam int TD_PAD_W    = TDATA_W - (CP_W + UNIT_W + CNT_W + 1 + HASH_W + 1);

    typedef struct packed {
        logic              kind;       // KIND_CHAR or KIND_END
        logic [CP_W-1:0]   code_point; // valid for KIND_CHAR
        logic              malformed;  // valid for KIND_END
    } t_u2j_evt;

endpackage

`default_nettype wire

FILE: sv/u2j_front.sv
`timescale 1ns / 1ps
`default_nettype none

// Byte decoder: sequence tracking, code point assembly, malformed detection.
module u2j_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire logic [7:0]        i_byte,
    output logic                   o_push,
    output u2j_pkg::t_u2j_evt      o_evt
);
    import u2j_pkg::*;

    localparam logic [7:0] BYTE_NUL  = 8'h00;
    localparam logic [7:0] BYTE_CONT = 8'h80;
    localparam logic [7:0] BYTE_LEAD = 8'hC0;

    logic [CP_W-1:0] r_acc, n_acc;
    logic [2:0]      r_rem, n_rem;
    logic            r_mal, n_mal;
    logic [CP_W-1:0] acc_sh;

    // payload bits kept from the lead byte
    function automatic logic [7:0] lead_mask(input logic [7:0] b);
        logic [7:0] m;
        if (b < 8'hE0)      m = 8'h1F;
        else if (b < 8'hF0) m = 8'h0F;
        else if (b < 8'hF8) m = 8'h07;
        else if (b < 8'hFC) m = 8'h03;
        else                m = 8'h01;
        return m;
    endfunction

    // continuation bytes still to come after the lead
    function automatic logic [2:0] lead_rem(input logic [7:0] b);
        logic [2:0] r;
        if (b < 8'hE0)      r = 3'd1;
        else if (b < 8'hF0) r = 3'd2;
        else if (b < 8'hF8) r = 3'd3;
        else if (b < 8'hFC) r = 3'd4;
        else                r = 3'd5;
        return r;
    endfunction

    assign acc_sh = {r_acc[CP_W-7:0], i_byte[5:0]};

    always_comb begin
        n_acc  = r_acc;
        n_rem  = r_rem;
        n_mal  = r_mal;
        o_push = 1'b0;
        o_evt  = '0;
        if (i_fire) begin
            priority if (i_byte == BYTE_NUL) begin
                o_push          = 1'b1;
                o_evt.kind      = KIND_END;
                o_evt.malformed = r_mal | (r_rem != 3'd0);
                n_acc           = '0;
                n_rem           = 3'd0;
                n_mal           = 1'b0;
            end else if (r_rem != 3'd0) begin
                n_rem = r_rem - 3'd1;
                if (r_rem == 3'd1) begin
                    o_push           = 1'b1;
                    o_evt.kind       = KIND_CHAR;
                    o_evt.code_point = acc_sh;
                    n_acc            = '0;
                end else begin
                    n_acc = acc_sh;
                end
            end else if (i_byte < BYTE_CONT) begin
                o_push           = 1'b1;
                o_evt.kind       = KIND_CHAR;
                o_evt.code_point = {{(CP_W-8){1'b0}}, i_byte};
            end else if (i_byte < BYTE_LEAD) begin
                n_mal = 1'b1;   // stray continuation, dropped
            end else begin
                n_acc = {{(CP_W-8){1'b0}}, i_byte & lead_mask(i_byte)};
                n_rem = lead_rem(i_byte);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_rem <= 3'd0;
            r_mal <= 1'b0;
        end else begin
            r_acc <= n_acc;
            r_rem <= n_rem;
            r_mal <= n_mal;
        end
    end

endmodule

`default_nettype wire

FILE: sv/u2j_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Small event FIFO between decoder and accumulator.
module u2j_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire u2j_pkg::t_u2j_evt i_push_evt,
    output logic                   o_full,
    input  wire logic              i_pop,
    output u2j_pkg::t_u2j_evt      o_pop_evt,
    output logic                   o_empty
);
    import u2j_pkg::*;

    t_u2j_evt              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QUEUE_CW-1:0]   r_count;
    logic                  do_push, do_pop;

    assign o_full    = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);
    assign do_push   = i_push && !o_full;
    assign do_pop    = i_pop && !o_empty;
    assign o_pop_evt = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        QUEUE_AW'(r_wr_ptr - r_rd_ptr) == QUEUE_AW'(r_count))
        else $error("queue pointers disagree with count");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !do_pop |=> r_count == QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue lost a full entry");

endmodule

`default_nettype wire

FILE: sv/u2j_back.sv
`timescale 1ns / 1ps
`default_nettype none

// String accumulator: count, Latin-1 check, Java hash, output register.
module u2j_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_empty,
    input  wire u2j_pkg::t_u2j_evt           i_evt,
    output logic                             o_pop,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic                             o_kind,
    output logic [u2j_pkg::CP_W-1:0]         o_code_point,
    output logic [u2j_pkg::UNIT_W-1:0]       o_code_unit,
    output logic [u2j_pkg::CNT_W-1:0]        o_char_count,
    output logic                             o_fits_latin1,
    output logic [u2j_pkg::HASH_W-1:0]       o_string_hash,
    output logic                             o_malformed
);
    import u2j_pkg::*;

    logic                 r_valid;
    logic                 r_kind;
    logic [CP_W-1:0]      r_cp;
    logic [UNIT_W-1:0]    r_unit;
    logic [CNT_W-1:0]     r_cnt_out;
    logic                 r_lat_out;
    logic [HASH_W-1:0]    r_hash_out;
    logic                 r_mal_out;

    logic [CNT_W-1:0]     r_cnt;
    logic                 r_latin1;
    logic [HASH_W-1:0]    r_hash;

    logic                 load;
    logic [HASH_W-1:0]    hash_next;
    logic [CNT_W-1:0]     cnt_next;

    assign load  = !r_valid || i_ready;
    assign o_pop = load && !i_empty;

    // 31*h + unit as (h << 5) - h + unit
    assign hash_next = {r_hash[HASH_W-6:0], 5'b0} - r_hash
                     + {{(HASH_W-UNIT_W){1'b0}}, i_evt.code_point[UNIT_W-1:0]};
    assign cnt_next  = (r_cnt == '1) ? r_cnt : r_cnt + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_cnt    <= '0;
            r_latin1 <= 1'b1;
            r_hash   <= '0;
        end else begin
            if (load) r_valid <= o_pop;
            if (o_pop) begin
                if (i_evt.kind == KIND_END) begin
                    r_cnt    <= '0;
                    r_latin1 <= 1'b1;
                    r_hash   <= '0;
                end else begin
                    r_cnt    <= cnt_next;
                    r_latin1 <= r_latin1 & (i_evt.code_point[CP_W-1:8] == '0);
                    r_hash   <= hash_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= i_evt.kind;
            if (i_evt.kind == KIND_END) begin
                r_cp       <= '0;
                r_unit     <= '0;
                r_cnt_out  <= r_cnt;
                r_lat_out  <= r_latin1;
                r_hash_out <= r_hash;
                r_mal_out  <= i_evt.malformed;
            end else begin
                r_cp       <= i_evt.code_point;
                r_unit     <= i_evt.code_point[UNIT_W-1:0];
                r_cnt_out  <= '0;
                r_lat_out  <= 1'b0;
                r_hash_out <= '0;
                r_mal_out  <= 1'b0;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_kind        = r_kind;
    assign o_code_point  = r_cp;
    assign o_code_unit   = r_unit;
    assign o_char_count  = r_cnt_out;
    assign o_fits_latin1 = r_lat_out;
    assign o_string_hash = r_hash_out;
    assign o_malformed   = r_mal_out;

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_evt.kind == KIND_END |=> r_cnt == '0 && r_latin1 && r_hash == '0)
        else $error("summary did not clear string state");

    a_no_pop_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |-> !o_pop)
        else $error("queue popped while result stalled");

    a_char_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_evt.kind == KIND_CHAR && r_cnt == '0 |=> r_cnt == CNT_W'(1))
        else $error("first character not counted");

endmodule

`default_nettype wire

FILE: sv/utf8_to_java_string_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Dir | Handshake                   | Payload
// ----------+-----+-----------------------------+------------------------------------
// s_axis    | in  | s_axis_tvalid/s_axis_tready | tdata[7:0] utf8_byte
// m_axis    | out | m_axis_tvalid/m_axis_tready | tuser result_kind; tdata see port
//
// One byte per cycle sustained while the event queue has room; a result
// passes through a queue entry, then the output register.
// Front stalls only when the four-entry event queue is full; back drains
// the queue whenever the output register is empty or being taken.
// Synchronous active-low reset clears decoder, queue and string state;
// no clearing pass.
module utf8_to_java_string_decoder (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [7:0] utf8_byte
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [30:0] code_point, [46:31] code_unit, [78:47] char_count,
    // [79] fits_latin1, [111:80] string_hash, [112] malformed, [119:113] zero
    output logic [u2j_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic              m_axis_tuser    // [0] result_kind
);
    import u2j_pkg::*;

    logic                 fire;
    logic                 push, full, pop, empty;
    t_u2j_evt             push_evt, pop_evt;
    logic [CP_W-1:0]      code_point;
    logic [UNIT_W-1:0]    code_unit;
    logic [CNT_W-1:0]     char_count;
    logic                 fits_latin1;
    logic [HASH_W-1:0]    string_hash;
    logic                 malformed;

    // the decoder emits at most one event per byte, so "not full" is enough
    assign s_axis_tready = !full;
    assign fire          = s_axis_tvalid && s_axis_tready;

    u2j_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (s_axis_tdata),
        .o_push  (push),
        .o_evt   (push_evt)
    );

    u2j_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_evt (push_evt),
        .o_full     (full),
        .i_pop      (pop),
        .o_pop_evt  (pop_evt),
        .o_empty    (empty)
    );

    u2j_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_evt         (pop_evt),
        .o_pop         (pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_kind        (m_axis_tuser),
        .o_code_point  (code_point),
        .o_code_unit   (code_unit),
        .o_char_count  (char_count),
        .o_fits_latin1 (fits_latin1),
        .o_string_hash (string_hash),
        .o_malformed   (malformed)
    );

    assign m_axis_tdata = {{TD_PAD_W{1'b0}}, malformed, string_hash, fits_latin1,
                           char_count, code_unit, code_point};

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps

// Stream-level check of utf8_to_java_string_decoder.
//
// A byte-by-byte predictor runs next to the block: every byte taken on the
// s_axis side is decoded here, and any result it causes (a character or an
// end-of-string summary) is queued. Every m_axis transaction is checked
// field by field against the oldest queued result.
//
// Stimulus order:
//   directed   - empty string, ASCII top, 2/4/6-byte sequences, stray
//                continuation, NUL inside a sequence, plain byte inside one
//   random     - strings of mostly well-formed characters with some noise,
//                run under three idle mixes (sender light / receiver heavy,
//                the reverse, then none)
//   pressure   - receiver held off for a long stretch while ASCII keeps
//                coming, so the event queue fills and s_axis_tready drops
module testbench;
    import u2j_pkg::*;

    localparam int          CYCLE_LIMIT = 200_000;
    localparam int          SETTLE      = 8;
    localparam logic [7:0]  NUL_BYTE    = 8'h00;
    localparam logic [7:0]  CONT_MIN    = 8'h80;  // first continuation byte
    localparam logic [7:0]  LEAD_MIN    = 8'hC0;  // first lead byte
    localparam logic [7:0]  CONT_TAG    = 8'h80;  // 10xxxxxx
    localparam logic [7:0]  PAYLOAD6    = 8'h3F;

    typedef struct packed {
        logic              kind;
        logic [CP_W-1:0]   code_point;
        logic [UNIT_W-1:0] code_unit;
        logic [CNT_W-1:0]  char_count;
        logic              fits_latin1;
        logic [HASH_W-1:0] string_hash;
        logic              malformed;
    } t_decoded;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;   // [7:0] utf8_byte
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [30:0] code_point, [46:31] code_unit, [78:47] char_count,
    // [79] fits_latin1, [111:80] string_hash, [112] malformed, [119:113] zero
    logic [TDATA_W-1:0]   m_axis_tdata;
    logic                 m_axis_tuser;         // [0] result_kind

    utf8_to_java_string_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Predictor state: one string in progress
    // ---------------------------------------------------------------
    logic [CP_W-1:0]   cp_acc           = '0;
    logic [2:0]        seq_left         = '0;   // continuation bytes still due
    logic [CNT_W-1:0]  chars_so_far     = '0;
    logic              latin1_so_far    = 1'b1;
    logic [HASH_W-1:0] hash_so_far      = '0;
    logic              malformed_so_far = 1'b0;

    t_decoded pending_decodes[$];   // results owed by the block, oldest first

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;          // receiver hold-off, counted down below
    int cycle_count   = 0;
    int error_count   = 0;
    int bytes_sent    = 0;
    int chars_checked = 0;
    int strings_checked   = 0;
    int malformed_strings = 0;
    int latin1_strings    = 0;

    // One finished character: update the running string state, owe a result.
    task automatic add_char(input logic [CP_W-1:0] cp);
        t_decoded r;
        r             = '0;
        r.kind        = KIND_CHAR;
        r.code_point  = cp;
        r.code_unit   = cp[UNIT_W-1:0];
        if (chars_so_far != '1)
            chars_so_far++;
        if (cp > 255)
            latin1_so_far = 1'b0;
        hash_so_far = hash_so_far * 32'd31 + {16'd0, cp[UNIT_W-1:0]};
        pending_decodes.push_back(r);
    endtask

    // Decode one accepted byte.
    task automatic decode_byte(input logic [7:0] b);
        t_decoded   r;
        logic [2:0] len;
        if (b == NUL_BYTE) begin
            // NUL in mid-sequence drops the partial char and flags the string
            if (seq_left != 0)
                malformed_so_far = 1'b1;
            r             = '0;
            r.kind        = KIND_END;
            r.char_count  = chars_so_far;
            r.fits_latin1 = latin1_so_far;
            r.string_hash = hash_so_far;
            r.malformed   = malformed_so_far;
            pending_decodes.push_back(r);
            cp_acc           = '0;
            seq_left         = '0;
            chars_so_far     = '0;
            latin1_so_far    = 1'b1;
            hash_so_far      = '0;
            malformed_so_far = 1'b0;
        end else if (seq_left != 0) begin
            // any nonzero byte counts as a continuation here
            cp_acc   = {cp_acc[CP_W-7:0], b[5:0]};
            seq_left = seq_left - 3'd1;
            if (seq_left == 0) begin
                add_char(cp_acc);
                cp_acc = '0;
            end
        end else if (b < CONT_MIN) begin
            add_char(CP_W'(b));
        end else if (b < LEAD_MIN) begin
            malformed_so_far = 1'b1;       // stray continuation, dropped
        end else begin
            if (b < 8'hE0)      len = 3'd2;
            else if (b < 8'hF0) len = 3'd3;
            else if (b < 8'hF8) len = 3'd4;
            else if (b < 8'hFC) len = 3'd5;
            else                len = 3'd6;
            cp_acc   = CP_W'(b & (8'hFF >> (len + 3'd1)));
            seq_left = len - 3'd1;
        end
    endtask

    // ---------------------------------------------------------------
    // Sender side. Called just after a falling edge; returns just after
    // one, with tvalid still high so back-to-back bytes need no gap.
    // ---------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            gap = $urandom_range(1, 4);
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        decode_byte(b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Drop tvalid and wait until the block has caught up with the predictor.
    task automatic wait_results_drained();
        s_axis_tvalid = 1'b0;
        while (pending_decodes.size() != 0)
            @(negedge i_clk);
    endtask

    function automatic logic [7:0] lead_byte(input int len);
        unique case (len)
            2:       return 8'($urandom_range(8'hC0, 8'hDF));
            3:       return 8'($urandom_range(8'hE0, 8'hEF));
            4:       return 8'($urandom_range(8'hF0, 8'hF7));
            5:       return 8'($urandom_range(8'hF8, 8'hFB));
            default: return 8'($urandom_range(8'hFC, 8'hFF));
        endcase
    endfunction

    function automatic logic [7:0] cont_byte();
        return CONT_TAG | (8'($urandom) & PAYLOAD6);
    endfunction

    // One character of len bytes; bent puts an arbitrary nonzero byte in
    // one continuation slot (the block still takes its low six bits).
    task automatic send_char(input int len, input bit bent);
        int bad_pos;
        if (len == 1) begin
            send_byte(8'($urandom_range(1, 127)));
        end else begin
            bad_pos = bent ? $urandom_range(1, len - 1) : 0;
            send_byte(lead_byte(len));
            for (int k = 1; k < len; k++)
                send_byte(k == bad_pos ? 8'($urandom_range(1, 255)) : cont_byte());
        end
    endtask

    // Mostly well-formed text with random content; a share of strings stays
    // inside Latin-1 so fits_latin1 comes back set with real characters.
    task automatic send_random_string();
        int n_chars;
        int pick;
        int len;
        bit latin_only;
        bit truncated;
        n_chars    = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                 : $urandom_range(0, 10);
        latin_only = ($urandom_range(0, 3) == 0);
        truncated  = 1'b0;
        for (int c = 0; c < n_chars && !truncated; c++) begin
            pick = $urandom_range(0, 99);
            if (latin_only) begin
                if (pick < 50) begin
                    send_char(1, 1'b0);
                end else begin
                    send_byte(LEAD_MIN | 8'($urandom_range(0, 3)));
                    send_byte(cont_byte());
                end
            end else if (pick < 80) begin
                send_char($urandom_range(1, 6), 1'b0);
            end else if (pick < 86) begin
                send_char($urandom_range(2, 6), 1'b1);
            end else if (pick < 92) begin
                send_byte(cont_byte());                     // stray continuation
            end else if (pick < 96) begin
                send_byte(8'($urandom_range(1, 255)));      // noise
            end else begin
                // sequence cut short by the terminator
                len = $urandom_range(2, 6);
                send_byte(lead_byte(len));
                repeat ($urandom_range(0, len - 2)) send_byte(cont_byte());
                truncated = 1'b1;
            end
        end
        send_byte(NUL_BYTE);
        if ($urandom_range(0, 24) == 0)
            wait_results_drained();
    endtask

    // ---------------------------------------------------------------
    // Receiver side: random tready, or a forced hold-off while hold_left
    // runs down.
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready = 1'b0;
            hold_left     = hold_left - 1;
        end else begin
            m_axis_tready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s got %0h, expected %0h", $time, field, got, want);
        error_count++;
    endtask

    // Compare each m_axis transaction with the oldest owed result.
    always @(posedge i_clk) begin : result_check
        t_decoded got;
        t_decoded want;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            got.kind        = m_axis_tuser;
            got.code_point  = m_axis_tdata[30:0];
            got.code_unit   = m_axis_tdata[46:31];
            got.char_count  = m_axis_tdata[78:47];
            got.fits_latin1 = m_axis_tdata[79];
            got.string_hash = m_axis_tdata[111:80];
            got.malformed   = m_axis_tdata[112];
            if (pending_decodes.size() == 0) begin
                report_mismatch("unexpected result, code_point", got.code_point, '0);
            end else begin
                want = pending_decodes.pop_front();
                if (got.kind !== want.kind)
                    report_mismatch("result_kind", got.kind, want.kind);
                if (got.code_point !== want.code_point)
                    report_mismatch("code_point", got.code_point, want.code_point);
                if (got.code_unit !== want.code_unit)
                    report_mismatch("code_unit", got.code_unit, want.code_unit);
                if (got.char_count !== want.char_count)
                    report_mismatch("char_count", got.char_count, want.char_count);
                if (got.fits_latin1 !== want.fits_latin1)
                    report_mismatch("fits_latin1", got.fits_latin1, want.fits_latin1);
                if (got.string_hash !== want.string_hash)
                    report_mismatch("string_hash", got.string_hash, want.string_hash);
                if (got.malformed !== want.malformed)
                    report_mismatch("malformed", got.malformed, want.malformed);
                if (m_axis_tdata[119:113] !== '0)
                    report_mismatch("tdata padding", m_axis_tdata[119:113], '0);
                if (want.kind == KIND_END) begin
                    strings_checked++;
                    if (want.malformed)   malformed_strings++;
                    if (want.fits_latin1) latin1_strings++;
                end else begin
                    chars_checked++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk)
        cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("run stopped at cycle %0d with %0d results outstanding",
                 cycle_count, pending_decodes.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_empty_string();
        send_byte(NUL_BYTE);
    endtask

    task automatic test_ascii_top();
        send_byte(8'h7F);
        send_byte(NUL_BYTE);
    endtask

    // 2-, 4- and 6-byte forms; the 6-byte one hits the largest code point
    task automatic test_multibyte_lengths();
        send_byte(8'hC3); send_byte(8'hA9);
        send_byte(8'hF0); send_byte(8'h9F); send_byte(8'h98); send_byte(8'h80);
        send_byte(8'hFD);
        repeat (5) send_byte(8'hBF);
        send_byte(NUL_BYTE);
    endtask

    task automatic test_stray_continuation();
        send_byte(8'h80);
        send_byte(8'hBF);
        send_byte(8'h01);
        send_byte(NUL_BYTE);
    endtask

    task automatic test_nul_in_sequence();
        send_byte(8'hE2);
        send_byte(8'h82);
        send_byte(NUL_BYTE);
    endtask

    // plain ASCII where a continuation belongs is still folded in
    task automatic test_plain_byte_in_sequence();
        send_byte(8'hC2);
        send_byte(8'h41);
        send_byte(NUL_BYTE);
    endtask

    task automatic test_random_strings(input int byte_budget);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < byte_budget)
            send_random_string();
    endtask

    // Receiver stalls long enough for the queue and output stage to fill;
    // the sender keeps offering and must see tready drop.
    task automatic test_receiver_hold();
        send_idle_pct = 0;
        hold_left     = 200;
        repeat (40) send_char(1, 1'b0);
        send_byte(NUL_BYTE);
        wait_results_drained();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_string();
        test_ascii_top();
        test_multibyte_lengths();
        test_stray_continuation();
        test_nul_in_sequence();
        test_plain_byte_in_sequence();
        wait_results_drained();

        send_idle_pct = 15;
        recv_idle_pct = 51;
        test_random_strings(650);
        send_idle_pct = 51;
        recv_idle_pct = 15;
        test_random_strings(650);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_strings(650);

        test_receiver_hold();

        wait_results_drained();
        repeat (SETTLE) @(posedge i_clk);

        $display("%0d bytes in, %0d characters and %0d strings checked",
                 bytes_sent, chars_checked, strings_checked);
        $display("%0d strings malformed, %0d within Latin-1, %0d field errors",
                 malformed_strings, latin1_strings, error_count);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
sv/u2j_pkg.sv
sv/u2j_front.sv
sv/u2j_queue.sv
sv/u2j_back.sv
sv/utf8_to_java_string_decoder.sv
tb/testbench.sv
